@@ rtl/pdr_pkg.sv @@
// Package for the page-addressed display RAM: transaction payload types and command codes.
// Depends on nothing; imported by page_addressed_display_ram.
package pdr_pkg;

    localparam logic [1:0] CMD_CONTROL = 2'd0;
    localparam logic [1:0] CMD_DATA    = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;
    localparam logic [1:0] CMD_READ    = 2'd3;

    localparam logic [3:0] NIB_PAGE    = 4'hB;
    localparam logic [3:0] NIB_COL_LO  = 4'h0;
    localparam logic [3:0] NIB_COL_HI  = 4'h1;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] value;
        logic [9:0] read_address;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] page_now;
        logic [7:0] column_now;
    } rsp_t;

endpackage

@@ rtl/page_addressed_display_ram.sv @@
// Page-addressed display RAM top level: page and column registers over one frame memory.
// A control, data or clear transaction has its response registered in the cycle after it is
// accepted; a read goes through the memory read register and then the response register.
// One control or data transaction per cycle while responses are taken; a read holds off the
// next transaction until it responds; a clear then zeroes one entry per cycle over all
// PAGES*COLUMNS entries, taking no transaction. Reset clears page and column and runs the same
// sweep (1024 entries by default) before the first transaction is accepted. Depends on pdr_pkg.
module page_addressed_display_ram #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  pdr_pkg::cmd_t cmd,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output pdr_pkg::rsp_t rsp
);
    import pdr_pkg::*;

    localparam int DEPTH  = PAGES * COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_CLEAR = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;
    logic [3:0]          page_reg, page_next;
    logic [7:0]          column_reg, column_next;
    logic [ADDR_W-1:0]   clear_cnt_reg, clear_cnt_next;
    logic                rd_ok_reg, rd_ok_next;

    logic [7:0]          mem [DEPTH];
    logic [7:0]          mem_rdata;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [7:0]          mem_wdata;
    logic                mem_re;

    logic                accept;
    logic                data_ok;
    logic [ADDR_W-1:0]   data_addr;
    logic [3:0]          high_nib;
    logic [3:0]          low_nib;

    assign cmd_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = cmd_valid && cmd_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign high_nib  = cmd.value[7:4];
    assign low_nib   = cmd.value[3:0];
    assign data_ok   = (32'(page_reg) < PAGES) && (32'(column_reg) < COLUMNS);
    assign data_addr = ADDR_W'(32'(page_reg) * COLUMNS + 32'(column_reg));

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        page_next      = page_reg;
        column_next    = column_reg;
        clear_cnt_next = clear_cnt_reg;
        rd_ok_next     = rd_ok_reg;
        mem_we         = 1'b0;
        mem_waddr      = data_addr;
        mem_wdata      = cmd.value;
        mem_re         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.command)
                        CMD_CONTROL:
                        begin
                            if (high_nib == NIB_PAGE)
                            begin
                                page_next = low_nib;
                            end
                            else if (high_nib == NIB_COL_LO)
                            begin
                                column_next = {column_reg[7:4], low_nib};
                            end
                            else if (high_nib == NIB_COL_HI)
                            begin
                                column_next = {low_nib, column_reg[3:0]};
                            end
                        end
                        CMD_DATA:
                        begin
                            if (data_ok)
                            begin
                                mem_we      = 1'b1;
                                column_next = column_reg + 8'd1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            state_next     = ST_CLEAR;
                            clear_cnt_next = '0;
                        end
                        CMD_READ:
                        begin
                            mem_re     = 1'b1;
                            rd_ok_next = 32'(cmd.read_address) < DEPTH;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (cmd.command != CMD_READ)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = '{read_data: 8'd0, page_now: page_next,
                                           column_now: column_next};
                    end
                end
            end
            ST_READ:
            begin
                rsp_valid_next = 1'b1;
                rsp_next       = '{read_data: rd_ok_reg ? mem_rdata : 8'd0,
                                   page_now: page_reg, column_now: column_reg};
                state_next     = ST_IDLE;
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clear_cnt_reg;
                mem_wdata = 8'd0;
                if (clear_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clear_cnt_next = clear_cnt_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
            page_reg      <= '0;
            column_reg    <= '0;
            clear_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            page_reg      <= page_next;
            column_reg    <= column_next;
            clear_cnt_reg <= clear_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg   <= rsp_next;
        rd_ok_reg <= rd_ok_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata <= mem[cmd.read_address[ADDR_W-1:0]];
        end
    end

`ifndef SYNTHESIS
    a_read_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.command == CMD_READ |=> state_reg == ST_READ ##1 rsp_valid)
        else $error("read response not delivered two cycles after acceptance");

    a_other_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.command != CMD_READ |=> rsp_valid)
        else $error("response missing one cycle after acceptance");

    a_regs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(page_reg) && $stable(column_reg))
        else $error("page or column changed without a transaction");

    a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> !mem_we)
        else $error("memory written while a read is pending");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for page_addressed_display_ram: drives command, data, clear and read
// transactions and checks every response against a predictor of the page and column registers
// and the frame memory. Depends on pdr_pkg and the page_addressed_display_ram RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pdr_pkg::*;

    localparam int COLUMNS = 128;
    localparam int PAGES = 8;
    localparam int STORE_DEPTH = PAGES * COLUMNS;
    localparam int QUIET_LIMIT = 20000;
    localparam int ITEMS_PER_PHASE = 175;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    logic [7:0] frame_mem [0:STORE_DEPTH-1];
    logic [3:0] page_reg;
    logic [7:0] column_reg;
    rsp_t expected_q [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    page_addressed_display_ram #(
        .COLUMNS(COLUMNS),
        .PAGES  (PAGES)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic rsp_t predict_display(input cmd_t item);
        rsp_t result;
        result.read_data = '0;
        case (item.command)
            CMD_CONTROL:
            begin
                if (item.value[7:4] == NIB_PAGE)
                    page_reg = item.value[3:0];
                else if (item.value[7:4] == NIB_COL_LO)
                    column_reg[3:0] = item.value[3:0];
                else if (item.value[7:4] == NIB_COL_HI)
                    column_reg[7:4] = item.value[3:0];
            end
            CMD_DATA:
            begin
                if (int'(page_reg) < PAGES && int'(column_reg) < COLUMNS)
                begin
                    frame_mem[10'(int'(page_reg) * COLUMNS + int'(column_reg))] = item.value;
                    column_reg = column_reg + 8'd1;
                end
            end
            CMD_CLEAR:
            begin
                foreach (frame_mem[i])
                    frame_mem[i] = '0;
            end
            default:
            begin
                if (int'(item.read_address) < STORE_DEPTH)
                    result.read_data = frame_mem[item.read_address];
            end
        endcase
        result.page_now = page_reg;
        result.column_now = column_reg;
        return result;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [7:0] val,
                             input logic [9:0] addr);
        cmd_t item;
        item.command = op;
        item.value = val;
        item.read_address = addr;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= item;
        do
            @(posedge clk);
        while (!cmd_ready);
        expected_q.push_back(predict_display(item));
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_q.size() != 0);
    endtask

    // Receiver side: stalls at random and checks each response against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected response read_data=%02h page=%0d column=%0d",
                             $realtime, rsp.read_data, rsp.page_now, rsp.column_now);
            end
            else
            begin
                if (rsp !== expected_q[0])
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch exp=%02h/%0d/%0d got=%02h/%0d/%0d",
                                 $realtime, expected_q[0].read_data,
                                 expected_q[0].page_now, expected_q[0].column_now,
                                 rsp.read_data, rsp.page_now, rsp.column_now);
                end
                void'(expected_q.pop_front());
            end
        end
        if (hold_off_cycles > 0)
        begin
            rsp_ready <= 1'b0;
            hold_off_cycles--;
        end
        else
        begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL page_addressed_display_ram");
            $finish;
        end
    end

    task automatic test_control_commands();
        send_item(CMD_CONTROL, {NIB_PAGE, 4'hF}, 10'h3FF);
        send_item(CMD_CONTROL, {NIB_COL_HI, 4'hF}, 10'h000);
        send_item(CMD_CONTROL, {NIB_COL_LO, 4'hF}, 10'h155);
        send_item(CMD_CONTROL, 8'h2A, 10'h2AA);
        send_item(CMD_CONTROL, 8'hFF, 10'h3FF);
        send_item(CMD_CONTROL, {NIB_PAGE, 4'h0}, 10'h000);
        send_item(CMD_CONTROL, {NIB_COL_LO, 4'h0}, 10'h000);
        send_item(CMD_CONTROL, {NIB_COL_HI, 4'h0}, 10'h000);
    endtask

    task automatic test_data_bounds();
        send_item(CMD_DATA, 8'hFF, 10'h3FF);
        send_item(CMD_DATA, 8'h00, 10'h000);
        send_item(CMD_CONTROL, {NIB_PAGE, 4'h7}, 10'h000);
        send_item(CMD_CONTROL, {NIB_COL_LO, 4'hF}, 10'h000);
        send_item(CMD_CONTROL, {NIB_COL_HI, 4'h7}, 10'h000);
        send_item(CMD_DATA, 8'hA5, 10'h000);
        send_item(CMD_DATA, 8'h5A, 10'h000);
        send_item(CMD_CONTROL, {NIB_PAGE, 4'h8}, 10'h000);
        send_item(CMD_CONTROL, {NIB_COL_LO, 4'h0}, 10'h000);
        send_item(CMD_CONTROL, {NIB_COL_HI, 4'h0}, 10'h000);
        send_item(CMD_DATA, 8'h3C, 10'h000);
    endtask

    task automatic test_reads();
        send_item(CMD_READ, 8'hFF, 10'h000);
        send_item(CMD_READ, 8'h00, 10'h001);
        send_item(CMD_READ, 8'h00, 10'h3FF);
        send_item(CMD_READ, 8'h00, 10'h3FE);
    endtask

    task automatic test_clear();
        send_item(CMD_CLEAR, 8'h00, 10'h000);
        send_item(CMD_READ, 8'h00, 10'h3FF);
        send_item(CMD_READ, 8'h00, 10'h000);
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_off_cycles = 300;
        repeat (40)
            send_item(($urandom_range(0, 1) != 0) ? CMD_DATA : CMD_READ,
                      8'($urandom_range(0, 255)), 10'($urandom_range(0, STORE_DEPTH - 1)));
        wait_drained();
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        int sent;
        int kind;
        int pg;
        int col;
        int len;
        int reads;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < ITEMS_PER_PHASE)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                pg = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 7);
                case ($urandom_range(0, 9))
                    0: col = $urandom_range(128, 255);
                    1, 2: col = COLUMNS - $urandom_range(1, 8);
                    default: col = $urandom_range(0, COLUMNS - 1);
                endcase
                send_item(CMD_CONTROL, {NIB_PAGE, pg[3:0]}, 10'($urandom_range(0, 1023)));
                send_item(CMD_CONTROL, {NIB_COL_LO, col[3:0]}, 10'($urandom_range(0, 1023)));
                send_item(CMD_CONTROL, {NIB_COL_HI, col[7:4]}, 10'($urandom_range(0, 1023)));
                len = $urandom_range(1, 16);
                repeat (len)
                    send_item(CMD_DATA, 8'($urandom_range(0, 255)),
                              10'($urandom_range(0, 1023)));
                reads = $urandom_range(1, 4);
                repeat (reads)
                    send_item(CMD_READ, 8'($urandom_range(0, 255)),
                              ($urandom_range(0, 1) != 0) ?
                              10'(pg * COLUMNS + col + $urandom_range(0, len - 1)) :
                              10'($urandom_range(0, 1023)));
                sent += 3 + len + reads;
            end
            else if (kind < 99)
            begin
                case ($urandom_range(0, 2))
                    0: send_item(CMD_CONTROL, 8'($urandom_range(0, 255)),
                                 10'($urandom_range(0, 1023)));
                    1: send_item(CMD_DATA, 8'($urandom_range(0, 255)),
                                 10'($urandom_range(0, 1023)));
                    default: send_item(CMD_READ, 8'($urandom_range(0, 255)),
                                       10'($urandom_range(0, 1023)));
                endcase
                sent++;
            end
            else
            begin
                send_item(CMD_CLEAR, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)));
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0);
        run_random_phase(56, 0);
        run_random_phase(0, 56);
        run_random_phase(21, 21);
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        foreach (frame_mem[i])
            frame_mem[i] = '0;
        page_reg = '0;
        column_reg = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_control_commands();
        test_data_bounds();
        test_reads();
        test_clear();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS page_addressed_display_ram");
        else
            $display("FAIL page_addressed_display_ram");
        $finish;
    end

endmodule

@@ page_addressed_display_ram.f @@
rtl/pdr_pkg.sv
rtl/page_addressed_display_ram.sv
tb/tb_top.sv
